// ===== design/psvm_pkg.sv =====
// ----------------------------------------------------------------------------
// psvm_pkg
// shared types and constants for the sample voice mixer
// ----------------------------------------------------------------------------
package psvm_pkg;

  localparam int unsigned CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_LOAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LEN  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TRIG = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP = 3'd4;

  localparam logic [15:0] GAIN_MAX = 16'd24576;
  localparam int unsigned GAIN_W = 15;
  localparam int unsigned ACC_W = 48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_VREAD,
    ST_VMAC,
    ST_FINISH,
    ST_STOP
  } state_t;

  // control from sequencer to the multiply accumulate unit
  typedef struct packed {
    logic clear;
    logic mac;
    logic mono;
  } mac_ctl_t;

  function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] q;
    q = acc >>> 7;
    if (q > $signed(48'sd8388607)) return 24'sh7fffff;
    else if (q < -$signed(48'sd8388608)) return 24'sh800000;
    else return q[23:0];
  endfunction

endpackage

// ===== design/psvm_mac.sv =====
// ----------------------------------------------------------------------------
// psvm_mac
// shared multiply accumulate unit, one voice channel pair per use
// ----------------------------------------------------------------------------
module psvm_mac (
  input  logic                            clk,
  input  psvm_pkg::mac_ctl_t              ctl,
  input  logic signed [15:0]              smp_l,
  input  logic signed [15:0]              smp_r,
  input  logic [psvm_pkg::GAIN_W-1:0]     gain,
  output logic signed [psvm_pkg::ACC_W-1:0] acc_l_r,
  output logic signed [psvm_pkg::ACC_W-1:0] acc_r_r
);
  logic signed [17:0] op_a, op_b;
  logic signed [15:0] g_s;
  logic signed [33:0] prod_a, prod_b;

  always_comb begin
    g_s = $signed({1'b0, gain});
    if (ctl.mono) begin
      op_a = 18'(smp_l) + 18'(smp_r);
      op_b = '0;
    end else begin
      op_a = 18'(smp_l) <<< 1;
      op_b = 18'(smp_r) <<< 1;
    end
    prod_a = op_a * g_s;
    prod_b = op_b * g_s;
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (ctl.mac) begin
      acc_l_r <= acc_l_r + psvm_pkg::ACC_W'(prod_a);
      acc_r_r <= acc_r_r + psvm_pkg::ACC_W'(prod_b);
    end
  end
endmodule

// ===== design/polyphonic_sample_voice_mixer_core.sv =====
// ----------------------------------------------------------------------------
// polyphonic_sample_voice_mixer_core
// sample slots, round robin voices and a serial mix into one output frame
// ----------------------------------------------------------------------------
// channel  | ports                         | handshake
// in       | start, busy, in_*             | start && !busy
// out      | out_valid, out_*              | one-cycle strobe, no stall
// cfg      | cfg_we, cfg_data              | write on cfg_we
// load, length and trigger finish in the command state; stop then clears each voice in turn.
// render tick walks the slots to launch pending triggers, then the
// one shared multiply accumulate unit visits each voice in turn.
// reset is synchronous and clears slots and voices; the sample memory is
// not cleared. results cannot be stalled by the receiver.
module polyphonic_sample_voice_mixer_core #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned VOICES     = 8,
  parameter int unsigned MAX_FRAMES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_command,
  input  logic [7:0]         in_slot,
  input  logic [11:0]        in_frame_index,
  input  logic [12:0]        in_length_frames,
  input  logic signed [15:0] in_sample_left,
  input  logic signed [15:0] in_sample_right,
  input  logic [15:0]        in_gain,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  output logic               out_valid,
  output logic               out_accepted,
  output logic signed [23:0] out_mix_left,
  output logic signed [23:0] out_mix_right
);
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned LW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned SCW = $clog2(SLOTS + 1);
  localparam int unsigned VCW = $clog2(VOICES + 1);
  localparam int unsigned DEPTH = SLOTS * MAX_FRAMES;
  localparam int unsigned AW = $clog2(DEPTH);

  psvm_pkg::state_t state_r, state_nxt;

  logic [1:0]  chan_r;
  logic [2:0]  cmd_r;
  logic [7:0]  slot_r;
  logic [11:0] fi_r;
  logic [12:0] len_r;
  logic [31:0] word_r;
  logic [15:0] gin_r;

  logic [LW-1:0] slot_len_r [SLOTS];
  logic [psvm_pkg::GAIN_W-1:0] slot_gain_r [SLOTS];
  logic [SLOTS-1:0] pend_r;
  logic [VOICES-1:0] vact_r;
  logic [SW-1:0] vslot_r [VOICES];
  logic [FW-1:0] vpos_r [VOICES];
  logic [psvm_pkg::GAIN_W-1:0] vgain_r [VOICES];
  logic [VW-1:0] next_r;
  logic [SCW-1:0] scnt_r;
  logic [VCW-1:0] vcnt_r;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_r;
  logic        rd_ok_r;

  psvm_pkg::mac_ctl_t mac_ctl;
  logic signed [psvm_pkg::ACC_W-1:0] acc_l, acc_r;

  logic slot_ok, ok_now, res_fire;
  logic [SW-1:0] s_idx, sc_idx;
  logic [VW-1:0] v_idx;
  logic [LW-1:0] cur_len;
  logic [FW:0] pos_inc;

  assign s_idx  = slot_r[SW-1:0];
  assign sc_idx = scnt_r[SW-1:0];
  assign v_idx  = vcnt_r[VW-1:0];
  assign slot_ok = ({24'd0, slot_r} < 32'(SLOTS));
  assign cur_len = slot_len_r[vslot_r[v_idx]];
  assign pos_inc = {1'b0, vpos_r[v_idx]} + 1'b1;
  assign busy = (state_r != psvm_pkg::ST_IDLE);

  always_comb begin
    unique case (cmd_r)
      psvm_pkg::CMD_LOAD: ok_now = slot_ok && ({20'd0, fi_r} < 32'(MAX_FRAMES));
      psvm_pkg::CMD_LEN:  ok_now = slot_ok && ({19'd0, len_r} <= 32'(MAX_FRAMES));
      psvm_pkg::CMD_TRIG: ok_now = slot_ok && (slot_len_r[s_idx] != '0);
      psvm_pkg::CMD_TICK: ok_now = (chan_r == 2'd1) || (chan_r == 2'd2);
      psvm_pkg::CMD_STOP: ok_now = 1'b1;
      default:            ok_now = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psvm_pkg::ST_IDLE: if (start) state_nxt = psvm_pkg::ST_FINISH;
      psvm_pkg::ST_LAUNCH: if (scnt_r == SCW'(SLOTS)) state_nxt = psvm_pkg::ST_VREAD;
      psvm_pkg::ST_VREAD:
        if (vcnt_r == VCW'(VOICES)) state_nxt = psvm_pkg::ST_IDLE;
        else state_nxt = psvm_pkg::ST_VMAC;
      psvm_pkg::ST_VMAC: state_nxt = psvm_pkg::ST_VREAD;
      psvm_pkg::ST_FINISH:
        if (ok_now && cmd_r == psvm_pkg::CMD_TICK) state_nxt = psvm_pkg::ST_LAUNCH;
        else if (ok_now && cmd_r == psvm_pkg::CMD_STOP) state_nxt = psvm_pkg::ST_STOP;
        else state_nxt = psvm_pkg::ST_IDLE;
      psvm_pkg::ST_STOP: if (vcnt_r == VCW'(VOICES)) state_nxt = psvm_pkg::ST_IDLE;
      default: state_nxt = psvm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mac_ctl.clear = (state_r == psvm_pkg::ST_FINISH);
    mac_ctl.mono  = (chan_r == 2'd1);
    mac_ctl.mac   = (state_r == psvm_pkg::ST_VMAC) && vact_r[v_idx] && rd_ok_r;
    res_fire = ((state_r == psvm_pkg::ST_FINISH) &&
                !(ok_now && (cmd_r == psvm_pkg::CMD_TICK || cmd_r == psvm_pkg::CMD_STOP))) ||
               ((state_r == psvm_pkg::ST_VREAD) && (vcnt_r == VCW'(VOICES))) ||
               ((state_r == psvm_pkg::ST_STOP) && (vcnt_r == VCW'(VOICES)));
  end

  psvm_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .smp_l   ($signed(rd_r[15:0])),
    .smp_r   ($signed(rd_r[31:16])),
    .gain    (vgain_r[v_idx]),
    .acc_l_r (acc_l),
    .acc_r_r (acc_r)
  );

  // sample memory: load writes, voice reads registered unconditionally
  always_ff @(posedge clk) begin
    if (state_r == psvm_pkg::ST_FINISH && cmd_r == psvm_pkg::CMD_LOAD && ok_now)
      mem[AW'({32'd0, s_idx} * 64'(MAX_FRAMES) + 64'(fi_r))] <= word_r;
    rd_r <= mem[AW'({32'd0, vslot_r[v_idx]} * 64'(MAX_FRAMES) + 64'(vpos_r[v_idx]))];
    rd_ok_r <= ({1'b0, vpos_r[v_idx]} < (FW+1)'(cur_len));
  end

  always_ff @(posedge clk) begin
    if (state_r == psvm_pkg::ST_IDLE && start) begin
      cmd_r  <= in_command;
      slot_r <= in_slot;
      fi_r   <= in_frame_index;
      len_r  <= in_length_frames;
      word_r <= {in_sample_right, in_sample_left};
      gin_r  <= in_gain;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= psvm_pkg::ST_IDLE;
      chan_r    <= 2'd2;
      pend_r    <= '0;
      vact_r    <= '0;
      next_r    <= '0;
      scnt_r    <= '0;
      vcnt_r    <= '0;
      out_valid <= 1'b0;
      out_accepted  <= 1'b0;
      out_mix_left  <= '0;
      out_mix_right <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_len_r[i]  <= '0;
        slot_gain_r[i] <= '0;
      end
      for (int i = 0; i < VOICES; i++) begin
        vslot_r[i] <= '0;
        vpos_r[i]  <= '0;
        vgain_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      out_valid <= res_fire;
      if (cfg_we) chan_r <= cfg_data;
      unique case (state_r)
        psvm_pkg::ST_FINISH: begin
          scnt_r <= '0;
          vcnt_r <= '0;
          if (!(ok_now && (cmd_r == psvm_pkg::CMD_TICK || cmd_r == psvm_pkg::CMD_STOP))) begin
            out_accepted  <= ok_now;
            out_mix_left  <= '0;
            out_mix_right <= '0;
          end
          if (ok_now && cmd_r == psvm_pkg::CMD_LEN) slot_len_r[s_idx] <= LW'(len_r);
          if (ok_now && cmd_r == psvm_pkg::CMD_TRIG) begin
            slot_gain_r[s_idx] <= (gin_r > psvm_pkg::GAIN_MAX) ?
                                  psvm_pkg::GAIN_W'(psvm_pkg::GAIN_MAX) :
                                  psvm_pkg::GAIN_W'(gin_r);
            pend_r[s_idx] <= 1'b1;
          end
        end
        psvm_pkg::ST_LAUNCH: begin
          if (scnt_r != SCW'(SLOTS)) begin
            scnt_r <= scnt_r + 1'b1;
            if (pend_r[sc_idx]) begin
              pend_r[sc_idx] <= 1'b0;
              if (slot_len_r[sc_idx] != '0) begin
                vact_r[next_r]  <= 1'b1;
                vslot_r[next_r] <= sc_idx;
                vpos_r[next_r]  <= '0;
                vgain_r[next_r] <= slot_gain_r[sc_idx];
                next_r <= (32'(next_r) == VOICES - 1) ? '0 : next_r + 1'b1;
              end
            end
          end
        end
        psvm_pkg::ST_VREAD: begin
          if (vcnt_r == VCW'(VOICES)) begin
            out_accepted  <= 1'b1;
            out_mix_left  <= psvm_pkg::sat24(acc_l);
            out_mix_right <= (chan_r == 2'd2) ? psvm_pkg::sat24(acc_r) : '0;
          end
        end
        psvm_pkg::ST_VMAC: begin
          vcnt_r <= vcnt_r + 1'b1;
          if (vact_r[v_idx]) begin
            if (rd_ok_r) begin
              if (pos_inc >= (FW+1)'(cur_len)) begin
                vact_r[v_idx] <= 1'b0;
                vpos_r[v_idx] <= '0;
              end else vpos_r[v_idx] <= FW'(pos_inc);
            end else begin
              vact_r[v_idx] <= 1'b0;
              vpos_r[v_idx] <= '0;
            end
          end
        end
        psvm_pkg::ST_STOP: begin
          if (vcnt_r == VCW'(VOICES)) begin
            out_accepted  <= 1'b1;
            out_mix_left  <= '0;
            out_mix_right <= '0;
          end else begin
            vcnt_r <= vcnt_r + 1'b1;
            vact_r[v_idx]  <= 1'b0;
            vslot_r[v_idx] <= '0;
            vpos_r[v_idx]  <= '0;
            vgain_r[v_idx] <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== design/psvm_checker.sv =====
// ----------------------------------------------------------------------------
// psvm_checker
// port level checks for the sample voice mixer
// ----------------------------------------------------------------------------
module psvm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic               out_accepted,
  input logic signed [23:0] out_mix_left,
  input logic signed [23:0] out_mix_right
);
  // a beat taken makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");
  // refused results carry zero mix
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |-> (out_mix_left == 0 && out_mix_right == 0))
    else $error("refused result not zero");
  // results only come while work is in flight
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without work");
  // no two results back to back
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
endmodule

bind polyphonic_sample_voice_mixer_core psvm_checker u_psvm_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_accepted(out_accepted), .out_mix_left(out_mix_left),
  .out_mix_right(out_mix_right)
);
